@@ hdl/chca_pkg.sv @@
// Package for the canonical code assignment block: field widths, sizes and
// limits shared by the channel interfaces and the top level. No dependencies.
package chca_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 31;
  localparam int CODE_WIDTH   = 16;

  localparam int SYM_W        = 8;
  localparam int LEN_W        = 5;
  localparam int OUT_CODE_W   = 16;
  localparam int COUNT_W      = 9;
  localparam int ACC_W        = 32;

  localparam int STORE_DEPTH  = 1 << SYM_W;
  localparam int LEN_SLOTS    = 1 << LEN_W;
  localparam int SCAN_W       = $clog2(STORE_DEPTH + 1);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

@@ hdl/chca_if.sv @@
// Valid/ready channel interfaces for the canonical code assignment block.
// Depends on chca_pkg for the payload widths.
interface chca_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [chca_pkg::SYM_W-1:0]  symbol;
  logic [chca_pkg::LEN_W-1:0]  code_length;
  logic                        last;

  modport source (output valid, func, symbol, code_length, last, input ready);
  modport sink   (input valid, func, symbol, code_length, last, output ready);
endinterface

interface chca_out_if;
  logic                             valid;
  logic                             ready;
  logic [chca_pkg::OUT_CODE_W-1:0]  code;
  logic [chca_pkg::LEN_W-1:0]       length_out;
  logic                             present;

  modport source (output valid, code, length_out, present, input ready);
  modport sink   (input valid, code, length_out, present, output ready);
endinterface

@@ hdl/canonical_huffman_code_assign_top.sv @@
// Top level of the canonical code assignment block: length and code memories
// and the sequencer that counts lengths, builds start codes and assigns codes.
// Depends on chca_pkg and the channel interfaces in chca_if.sv.
//
// Usage. Each input word on in_ch is a load (func 0) or a query (func 1).
// A load writes the code length of one symbol; lengths above the maximum are
// clamped. The load marked last starts code assignment. A query returns one
// word on out_ch with the symbol's code, its length and a presence flag.
//
// Timing. A query first reads the memories, then the output register is
// loaded. The last load starts an assignment: one scan of the length memory
// to count lengths, one 32-bit add per length to build the start codes, and a
// second scan that writes the code memory, one symbol a cycle through the
// single read port of the length memory. in_ch.ready is low throughout. A
// query may be accepted while the previous result still waits; if out_ch
// stalls, the new query holds in ST_QUERY until the output register frees up.
//
// Reset. After rst_n a clearing pass writes zero to every entry of both
// memories; in_ch.ready stays low until it is done.
module canonical_huffman_code_assign_top (
  input  logic               clk,
  input  logic               rst_n,
  chca_in_if.sink            in_ch,
  chca_out_if.source         out_ch
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_COUNT,
    ST_PREFIX,
    ST_ASSIGN
  } state_t;

  state_t                               state_r;
  logic [chca_pkg::SCAN_W-1:0]          scan_r;
  logic                                 rd_vld_r;
  logic [chca_pkg::SYM_W-1:0]           rd_sym_r;
  logic [chca_pkg::LEN_W-1:0]           len_rd_r;
  logic [chca_pkg::CODE_WIDTH-1:0]      code_rd_r;
  logic                                 qrange_r;
  logic [chca_pkg::LEN_W-1:0]           slot_r;
  logic [chca_pkg::ACC_W-1:0]           acc_r;
  logic [chca_pkg::COUNT_W-1:0]         count_r [chca_pkg::LEN_SLOTS];
  logic [chca_pkg::ACC_W-1:0]           next_code_r [chca_pkg::LEN_SLOTS];

  logic                                 out_valid_r;
  logic [chca_pkg::OUT_CODE_W-1:0]      out_code_r;
  logic [chca_pkg::LEN_W-1:0]           out_len_r;
  logic                                 out_present_r;

  // Memories.
  logic [chca_pkg::LEN_W-1:0]           len_mem [chca_pkg::STORE_DEPTH];
  logic [chca_pkg::CODE_WIDTH-1:0]      code_mem [chca_pkg::STORE_DEPTH];

  logic                                 in_fire;
  logic                                 in_range;
  logic [chca_pkg::LEN_W-1:0]           len_clamped;
  logic                                 scan_issue;
  logic                                 scan_done;
  logic                                 len_we;
  logic                                 len_re;
  logic [chca_pkg::SYM_W-1:0]           len_waddr;
  logic [chca_pkg::LEN_W-1:0]           len_wdata;
  logic [chca_pkg::SYM_W-1:0]           len_raddr;
  logic                                 code_we;
  logic [chca_pkg::SYM_W-1:0]           code_waddr;
  logic [chca_pkg::CODE_WIDTH-1:0]      code_wdata;
  logic [chca_pkg::ACC_W-1:0]           acc_nxt;
  logic                                 out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = {1'b0, in_ch.symbol} < chca_pkg::SCAN_W'(chca_pkg::NUM_SYMBOLS);
  assign len_clamped = (in_ch.code_length > chca_pkg::LEN_W'(chca_pkg::MAX_CODE_LEN))
                       ? chca_pkg::LEN_W'(chca_pkg::MAX_CODE_LEN) : in_ch.code_length;

  // Both scans walk the symbols once; a read lands in the cycle after its issue.
  assign scan_issue  = ((state_r == ST_COUNT) || (state_r == ST_ASSIGN)) &&
                       (scan_r < chca_pkg::SCAN_W'(chca_pkg::NUM_SYMBOLS));
  assign scan_done   = !scan_issue && !rd_vld_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  // The read registers hold their data while a query waits for the output.
  assign len_re      = in_fire || scan_issue;

  // Start code for the next length: add the count of the previous length and
  // step one bit longer.
  assign acc_nxt = (acc_r + chca_pkg::ACC_W'(count_r[slot_r - 1'b1])) << 1;

  always_comb begin
    len_raddr = (state_r == ST_IDLE) ? in_ch.symbol : scan_r[chca_pkg::SYM_W-1:0];
    if (state_r == ST_CLEAR) begin
      len_we    = 1'b1;
      len_waddr = scan_r[chca_pkg::SYM_W-1:0];
      len_wdata = '0;
    end else begin
      len_we    = in_fire && (in_ch.func == chca_pkg::FUNC_LOAD) && in_range;
      len_waddr = in_ch.symbol;
      len_wdata = len_clamped;
    end
    if (state_r == ST_CLEAR) begin
      code_we    = 1'b1;
      code_waddr = scan_r[chca_pkg::SYM_W-1:0];
      code_wdata = '0;
    end else begin
      code_we    = (state_r == ST_ASSIGN) && rd_vld_r;
      code_waddr = rd_sym_r;
      code_wdata = (len_rd_r == '0) ? '0
                   : next_code_r[len_rd_r][chca_pkg::CODE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rd_r <= len_mem[len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    if (in_fire) begin
      code_rd_r <= code_mem[in_ch.symbol];
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
      rd_sym_r <= scan_r[chca_pkg::SYM_W-1:0];
      if (out_valid_r && out_ch.ready && (state_r != ST_QUERY)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (scan_r[chca_pkg::SYM_W-1:0] == chca_pkg::SYM_W'(chca_pkg::STORE_DEPTH - 1)) begin
            scan_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.func == chca_pkg::FUNC_QUERY) begin
              qrange_r <= in_range;
              state_r  <= ST_QUERY;
            end else if (in_ch.last) begin
              for (int i = 0; i < chca_pkg::LEN_SLOTS; i++) begin
                count_r[i] <= '0;
              end
              scan_r  <= '0;
              state_r <= ST_COUNT;
            end
          end
        end
        ST_QUERY: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_code_r    <= qrange_r ? chca_pkg::OUT_CODE_W'(code_rd_r) : '0;
            out_len_r     <= qrange_r ? len_rd_r : '0;
            out_present_r <= qrange_r && (len_rd_r != '0);
            state_r       <= ST_IDLE;
          end
        end
        ST_COUNT: begin
          if (scan_issue) begin
            scan_r <= scan_r + 1'b1;
          end
          if (rd_vld_r && (len_rd_r != '0)) begin
            count_r[len_rd_r] <= count_r[len_rd_r] + 1'b1;
          end
          if (scan_done) begin
            slot_r  <= chca_pkg::LEN_W'(1);
            acc_r   <= '0;
            state_r <= ST_PREFIX;
          end
        end
        ST_PREFIX: begin
          next_code_r[slot_r] <= acc_nxt;
          acc_r               <= acc_nxt;
          if (slot_r == chca_pkg::LEN_W'(chca_pkg::LEN_SLOTS - 1)) begin
            scan_r  <= '0;
            state_r <= ST_ASSIGN;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        ST_ASSIGN: begin
          if (scan_issue) begin
            scan_r <= scan_r + 1'b1;
          end
          if (rd_vld_r && (len_rd_r != '0)) begin
            next_code_r[len_rd_r] <= next_code_r[len_rd_r] + 1'b1;
          end
          if (scan_done) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code       = out_code_r;
  assign out_ch.length_out = out_len_r;
  assign out_ch.present    = out_present_r;

endmodule
